[rtl/ffba_pkg.sv]
package ffba_pkg;

    // payload widths of the request and response channels
    localparam int SIZE_W   = 19;
    localparam int OFFS_W   = 32;
    localparam int STATUS_W = 2;
    localparam int START_W  = 10;
    localparam int RUN_W    = 11;
    localparam int USED_W   = 11;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_NOSPACE = 2'd1,
        STAT_ZERO    = 2'd2,
        STAT_IGNORED = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_WALK,
        ST_FINISH
    } state_t;

endpackage

[rtl/ffba_req_if.sv]
interface ffba_req_if;

    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [ffba_pkg::SIZE_W-1:0] size_bytes;
    logic [ffba_pkg::OFFS_W-1:0] byte_offset;

    modport source (output valid, mode, size_bytes, byte_offset, input ready);
    modport sink   (input valid, mode, size_bytes, byte_offset, output ready);

endinterface

[rtl/ffba_rsp_if.sv]
interface ffba_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [ffba_pkg::STATUS_W-1:0] status;
    logic [ffba_pkg::START_W-1:0]  start_block;
    logic [ffba_pkg::RUN_W-1:0]    run_blocks;
    logic [ffba_pkg::USED_W-1:0]   used_total;

    modport source (output valid, status, start_block, run_blocks, used_total, input ready);
    modport sink   (input valid, status, start_block, run_blocks, used_total, output ready);

endinterface

[rtl/first_fit_block_allocator_unit.sv]
// channel  direction  handshake      payload
// req      in         valid / ready  mode, size_bytes, byte_offset
// rsp      out        valid / ready  status, start_block, run_blocks, used_total
//
// one request at a time; the block flag memory is read one block per cycle
// allocate: first-fit scan over the flag memory, then marking of the found run
// free: flag walk over the stored run; size errors go straight to the response
// after reset a clearing pass initializes both memories, req not ready
// the response register holds a result while rsp stalls; the next request is accepted
// meanwhile and waits only when its own result is ready
// BLOCK_BYTES must be a power of two
module first_fit_block_allocator_unit #(
    parameter int NUM_BLOCKS  = 1024,
    parameter int BLOCK_BYTES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    ffba_req_if.sink   req,
    ffba_rsp_if.source rsp
);

    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int SHIFT  = $clog2(BLOCK_BYTES);
    localparam int NEED_W = ffba_pkg::SIZE_W + 1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);
    localparam logic [CNT_W-1:0] NUM_CNT  = CNT_W'(NUM_BLOCKS);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    // block memories
    logic             flag_mem [NUM_BLOCKS];
    logic [CNT_W-1:0] run_mem  [NUM_BLOCKS];

    ffba_pkg::state_t  state_reg, state_next;
    ffba_pkg::status_t st_reg, st_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] done_reg, done_next;
    logic [IDX_W-1:0] base_reg, base_next;
    logic [IDX_W-1:0] data_addr_reg, data_addr_next;
    logic             data_vld_reg, data_vld_next;
    logic [CNT_W-1:0] need_reg, need_next;
    logic [IDX_W-1:0] cand_reg, cand_next;
    logic [CNT_W-1:0] run_cnt_reg, run_cnt_next;
    logic [IDX_W-1:0] blk_reg, blk_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0] res_start_reg, res_start_next;
    logic [CNT_W-1:0] res_run_reg, res_run_next;

    logic                            out_valid_reg, out_valid_next;
    logic [ffba_pkg::STATUS_W-1:0]   out_status_reg;
    logic [ffba_pkg::START_W-1:0]    out_start_reg;
    logic [ffba_pkg::RUN_W-1:0]      out_run_reg;
    logic [ffba_pkg::USED_W-1:0]     out_used_reg;

    // memory ports
    logic             flag_we, flag_wdata, flag_re, flag_q;
    logic [IDX_W-1:0] flag_waddr, raddr;
    logic             run_we, run_re;
    logic [IDX_W-1:0] run_waddr;
    logic [CNT_W-1:0] run_wdata, run_q;

    // shared decode
    logic              accept;
    logic [NEED_W-1:0] need_w;
    logic [ffba_pkg::OFFS_W-1:0] offs_blk;
    logic              offs_oor, need_big;
    logic [CNT_W-1:0]  limit;
    logic              issue;
    logic [IDX_W-1:0]  rd_addr;
    logic [CNT_W-1:0]  run_inc;
    logic [IDX_W-1:0]  cand_sel;
    logic              hit, at_end;
    logic              mark_last, walk_last, clear_last;
    logic [CNT_W-1:0]  len_raw, room, len_sel;
    logic              out_free;

    assign accept   = req.valid && req.ready;
    assign need_w   = (NEED_W'(req.size_bytes) + NEED_W'(BLOCK_BYTES - 1)) >> SHIFT;
    assign need_big = need_w > NEED_W'(NUM_BLOCKS);
    assign offs_blk = req.byte_offset >> SHIFT;
    assign offs_oor = offs_blk >= ffba_pkg::OFFS_W'(NUM_BLOCKS);

    assign limit   = (state_reg == ffba_pkg::ST_SCAN) ? NUM_CNT : len_reg;
    assign issue   = ((state_reg == ffba_pkg::ST_SCAN) || (state_reg == ffba_pkg::ST_WALK))
                     && (cnt_reg < limit);
    assign rd_addr = base_reg + cnt_reg[IDX_W-1:0];

    // first-fit run tracking on the returned flag
    assign run_inc  = run_cnt_reg + ONE_CNT;
    assign cand_sel = (run_cnt_reg == '0) ? data_addr_reg : cand_reg;
    assign hit      = data_vld_reg && flag_q && (run_inc >= need_reg);
    assign at_end   = data_addr_reg == LAST_IDX;

    assign mark_last  = cnt_reg == need_reg - ONE_CNT;
    assign walk_last  = data_vld_reg && (done_reg == len_reg - ONE_CNT);
    assign clear_last = cnt_reg == NUM_CNT - ONE_CNT;

    // free length: stored 0 counts as 1, cut at the pool end
    assign len_raw = (run_q == '0) ? ONE_CNT : run_q;
    assign room    = NUM_CNT - CNT_W'(blk_reg);
    assign len_sel = (len_raw > room) ? room : len_raw;

    assign out_free = !out_valid_reg || rsp.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffba_pkg::ST_CLEAR:
            begin
                if (clear_last)
                    state_next = ffba_pkg::ST_IDLE;
            end
            ffba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.mode)
                        state_next = offs_oor ? ffba_pkg::ST_FINISH : ffba_pkg::ST_FREE_RD;
                    else if (req.size_bytes == '0 || need_big)
                        state_next = ffba_pkg::ST_FINISH;
                    else
                        state_next = ffba_pkg::ST_SCAN;
                end
            end
            ffba_pkg::ST_SCAN:
            begin
                if (hit)
                    state_next = ffba_pkg::ST_MARK;
                else if (data_vld_reg && at_end)
                    state_next = ffba_pkg::ST_FINISH;
            end
            ffba_pkg::ST_MARK:
            begin
                if (mark_last)
                    state_next = ffba_pkg::ST_FINISH;
            end
            ffba_pkg::ST_FREE_RD:
                state_next = ffba_pkg::ST_FREE_CHK;
            ffba_pkg::ST_FREE_CHK:
                state_next = flag_q ? ffba_pkg::ST_FINISH : ffba_pkg::ST_WALK;
            ffba_pkg::ST_WALK:
            begin
                if (walk_last)
                    state_next = ffba_pkg::ST_FINISH;
            end
            ffba_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = ffba_pkg::ST_IDLE;
            end
            default:
                state_next = ffba_pkg::ST_CLEAR;
        endcase
    end

    // memory controls and handshake outputs
    always_comb
    begin
        flag_we    = 1'b0;
        flag_waddr = rd_addr;
        flag_wdata = 1'b0;
        flag_re    = 1'b0;
        run_we     = 1'b0;
        run_waddr  = base_reg;
        run_wdata  = need_reg;
        run_re     = 1'b0;
        raddr      = rd_addr;
        req.ready  = 1'b0;
        case (state_reg)
            ffba_pkg::ST_CLEAR:
            begin
                flag_we    = 1'b1;
                flag_wdata = 1'b1;
                run_we     = 1'b1;
                run_waddr  = rd_addr;
                run_wdata  = '0;
            end
            ffba_pkg::ST_IDLE:
                req.ready = 1'b1;
            ffba_pkg::ST_SCAN:
                flag_re = issue;
            ffba_pkg::ST_MARK:
            begin
                flag_we = 1'b1;
                run_we  = cnt_reg == '0;
            end
            ffba_pkg::ST_FREE_RD:
            begin
                flag_re = 1'b1;
                run_re  = 1'b1;
                raddr   = blk_reg;
            end
            ffba_pkg::ST_WALK:
            begin
                flag_re    = issue;
                flag_we    = data_vld_reg;
                flag_waddr = data_addr_reg;
                flag_wdata = 1'b1;
            end
            default:
            begin
                flag_we = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        cnt_next       = cnt_reg;
        done_next      = done_reg;
        base_next      = base_reg;
        data_addr_next = rd_addr;
        data_vld_next  = issue;
        need_next      = need_reg;
        cand_next      = cand_reg;
        run_cnt_next   = run_cnt_reg;
        blk_next       = blk_reg;
        len_next       = len_reg;
        used_next      = used_reg;
        st_next        = st_reg;
        res_start_next = res_start_reg;
        res_run_next   = res_run_reg;
        case (state_reg)
            ffba_pkg::ST_CLEAR:
            begin
                cnt_next = clear_last ? '0 : cnt_reg + ONE_CNT;
            end
            ffba_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next       = '0;
                    base_next      = '0;
                    run_cnt_next   = '0;
                    need_next      = need_w[CNT_W-1:0];
                    blk_next       = offs_blk[IDX_W-1:0];
                    res_start_next = '0;
                    res_run_next   = '0;
                    if (req.mode)
                        st_next = ffba_pkg::STAT_IGNORED;
                    else if (req.size_bytes == '0)
                        st_next = ffba_pkg::STAT_ZERO;
                    else
                        st_next = ffba_pkg::STAT_NOSPACE;
                end
            end
            ffba_pkg::ST_SCAN:
            begin
                if (issue)
                    cnt_next = cnt_reg + ONE_CNT;
                if (data_vld_reg)
                begin
                    if (flag_q)
                    begin
                        run_cnt_next = run_inc;
                        cand_next    = cand_sel;
                    end
                    else
                        run_cnt_next = '0;
                end
                if (hit)
                begin
                    base_next      = cand_sel;
                    cnt_next       = '0;
                    st_next        = ffba_pkg::STAT_OK;
                    res_start_next = cand_sel;
                    res_run_next   = need_reg;
                end
            end
            ffba_pkg::ST_MARK:
            begin
                cnt_next = cnt_reg + ONE_CNT;
                if (mark_last)
                    used_next = used_reg + need_reg;
            end
            ffba_pkg::ST_FREE_CHK:
            begin
                if (!flag_q)
                begin
                    len_next       = len_sel;
                    base_next      = blk_reg;
                    cnt_next       = '0;
                    done_next      = '0;
                    st_next        = ffba_pkg::STAT_OK;
                    res_start_next = blk_reg;
                    res_run_next   = len_sel;
                end
            end
            ffba_pkg::ST_WALK:
            begin
                if (issue)
                    cnt_next = cnt_reg + ONE_CNT;
                if (data_vld_reg)
                begin
                    done_next = done_reg + ONE_CNT;
                    if (!flag_q && used_reg != '0)
                        used_next = used_reg - ONE_CNT;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // response register
    assign out_valid_next = (out_valid_reg && !rsp.ready)
                            || (state_reg == ffba_pkg::ST_FINISH && out_free);

    always_ff @(posedge clk)
    begin
        if (state_reg == ffba_pkg::ST_FINISH && out_free)
        begin
            out_status_reg <= st_reg;
            out_start_reg  <= ffba_pkg::START_W'(res_start_reg);
            out_run_reg    <= ffba_pkg::RUN_W'(res_run_reg);
            out_used_reg   <= ffba_pkg::USED_W'(used_reg);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.start_block = out_start_reg;
    assign rsp.run_blocks  = out_run_reg;
    assign rsp.used_total  = out_used_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffba_pkg::ST_CLEAR;
            cnt_reg       <= '0;
            done_reg      <= '0;
            base_reg      <= '0;
            data_vld_reg  <= 1'b0;
            run_cnt_reg   <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
            base_reg      <= base_next;
            data_vld_reg  <= data_vld_next;
            run_cnt_reg   <= run_cnt_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        data_addr_reg <= data_addr_next;
        need_reg      <= need_next;
        cand_reg      <= cand_next;
        blk_reg       <= blk_next;
        len_reg       <= len_next;
        st_reg        <= st_next;
        res_start_reg <= res_start_next;
        res_run_reg   <= res_run_next;
    end

    // free flag memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (flag_we)
            flag_mem[flag_waddr] <= flag_wdata;
        if (flag_re)
            flag_q <= flag_mem[raddr];
    end

    // run length memory
    always_ff @(posedge clk)
    begin
        if (run_we)
            run_mem[run_waddr] <= run_wdata;
        if (run_re)
            run_q <= run_mem[raddr];
    end

endmodule

[rtl/ffba_checker.sv]
module ffba_checker #(
    parameter int NUM_BLOCKS = 1024
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [ffba_pkg::STATUS_W-1:0] status,
    input logic [ffba_pkg::START_W-1:0]  start_block,
    input logic [ffba_pkg::RUN_W-1:0]    run_blocks,
    input logic [ffba_pkg::USED_W-1:0]   used_total
);

    // stalled response keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(start_block)
            && $stable(run_blocks) && $stable(used_total))
        else $error("response changed while stalled");

    // failed requests report an empty run
    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != ffba_pkg::STAT_OK |-> start_block == '0 && run_blocks == '0)
        else $error("failed request reports a run");

    // a successful request always covers at least one block
    a_ok_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ffba_pkg::STAT_OK && NUM_BLOCKS < 2048 |-> run_blocks != '0)
        else $error("successful request with empty run");

    // used count never exceeds the pool
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && NUM_BLOCKS < 2048 |-> 32'(used_total) <= 32'(NUM_BLOCKS))
        else $error("used count above pool size");

endmodule

bind first_fit_block_allocator_unit ffba_checker #(.NUM_BLOCKS(NUM_BLOCKS)) u_ffba_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .start_block (rsp.start_block),
    .run_blocks  (rsp.run_blocks),
    .used_total  (rsp.used_total)
);
